// File: hw/rtl/tbfs_pkg.sv
// ----------------------------------------------------------------------------
// tbfs_pkg
// Shared types and constants of the background tile fetch and scroll block.
// ----------------------------------------------------------------------------
package tbfs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_BG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_SPR_ENABLE    = 3'd1;
  localparam logic [2:0] CFG_PATTERN_HALF  = 3'd2;
  localparam logic [2:0] CFG_FINE_X        = 3'd3;
  localparam logic [2:0] CFG_TEMP_ADDRESS  = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // scanline range with background work
  localparam logic signed [9:0] LINE_PRE  = -10'sd1;
  localparam logic signed [9:0] LINE_LAST = 10'sd239;

  // dot landmarks
  localparam logic [8:0] DOT_FETCH_FIRST   = 9'd2;
  localparam logic [8:0] DOT_FETCH_END     = 9'd258;
  localparam logic [8:0] DOT_PRE_FIRST     = 9'd321;
  localparam logic [8:0] DOT_PRE_END       = 9'd338;
  localparam logic [8:0] DOT_INC_Y         = 9'd256;
  localparam logic [8:0] DOT_COPY_H        = 9'd257;
  localparam logic [8:0] DOT_NAME_A        = 9'd338;
  localparam logic [8:0] DOT_NAME_B        = 9'd340;
  localparam logic [8:0] DOT_COPY_V_FIRST  = 9'd280;
  localparam logic [8:0] DOT_COPY_V_END    = 9'd305;

  // phase within an eight-dot tile slot
  localparam logic [2:0] PH_NAME  = 3'd0;
  localparam logic [2:0] PH_ATTR  = 3'd2;
  localparam logic [2:0] PH_LOW   = 3'd4;
  localparam logic [2:0] PH_HIGH  = 3'd6;
  localparam logic [2:0] PH_INC_X = 3'd7;

  // memory map constants
  localparam logic [13:0] NAME_BASE    = 14'h2000;
  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam logic [4:0]  COARSE_MAX   = 5'd31;
  localparam logic [4:0]  COARSE_Y_ROW = 5'd29;
  localparam logic [2:0]  FINE_Y_MAX   = 3'd7;

  // queue depths
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = 2;
  localparam int CMD_CNT_W  = 3;
  localparam int OUT_DEPTH  = 2;
  localparam int OUT_PTR_W  = 1;
  localparam int OUT_CNT_W  = 2;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_NAME = 3'd1,
    KIND_ATTR = 3'd2,
    KIND_LOW  = 3'd3,
    KIND_HIGH = 3'd4
  } fetch_kind_t;

  typedef struct packed {
    logic        bg_enable;
    logic        spr_enable;
    logic        pattern_half;
    logic [2:0]  fine_x;
    logic [14:0] temp_address;
  } cfg_t;

  // one classified dot for the back end
  typedef struct packed {
    logic        shift;
    logic        load;
    fetch_kind_t fetch;
    logic        bump_x;
    logic        bump_y;
    logic        copy_h;
    logic        copy_v;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic        fetch_valid;
    logic [13:0] fetch_address;
    logic [1:0]  palette_select;
    logic [1:0]  pixel_value;
    logic [13:0] palette_ram_address;
  } result_t;

endpackage

// File: hw/rtl/tbfs_front.sv
// ----------------------------------------------------------------------------
// tbfs_front
// Takes dot requests, classifies each dot into its background work and
// queues the command for the back end.
// ----------------------------------------------------------------------------
module tbfs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [8:0]        in_dot,
  input  logic signed [9:0] in_line,
  input  logic [7:0]        in_fetch_data,
  output logic              cmd_valid,
  output tbfs_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);
  import tbfs_pkg::*;

  logic                 active;
  logic                 win;
  logic [2:0]           phase;
  cmd_t                 dec;
  logic                 push_ok;
  logic                 pop_ok;
  cmd_t                 q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;
  logic [CMD_CNT_W-1:0] count_nxt;

  always_comb begin
    active = (in_line >= LINE_PRE) && (in_line <= LINE_LAST);
    win    = ((in_dot >= DOT_FETCH_FIRST) && (in_dot < DOT_FETCH_END)) ||
             ((in_dot >= DOT_PRE_FIRST) && (in_dot < DOT_PRE_END));
    phase  = in_dot[2:0] - 3'd1;

    dec        = '0;
    dec.data   = in_fetch_data;
    dec.fetch  = KIND_NONE;
    dec.shift  = active && win;
    dec.load   = active && ((win && (phase == PH_NAME)) || (in_dot == DOT_COPY_H));
    dec.bump_x = active && win && (phase == PH_INC_X);
    dec.bump_y = active && (in_dot == DOT_INC_Y);
    dec.copy_h = active && (in_dot == DOT_COPY_H);
    dec.copy_v = active && (in_line == LINE_PRE) &&
                 (in_dot >= DOT_COPY_V_FIRST) && (in_dot < DOT_COPY_V_END);
    if (active && ((in_dot == DOT_NAME_A) || (in_dot == DOT_NAME_B))) begin
      dec.fetch = KIND_NAME;
    end else if (active && win) begin
      unique case (phase)
        PH_NAME: dec.fetch = KIND_NAME;
        PH_ATTR: dec.fetch = KIND_ATTR;
        PH_LOW:  dec.fetch = KIND_LOW;
        PH_HIGH: dec.fetch = KIND_HIGH;
        default: dec.fetch = KIND_NONE;
      endcase
    end
  end

  assign in_full   = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_ok && pop_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: hw/rtl/tbfs_back.sv
// ----------------------------------------------------------------------------
// tbfs_back
// Carries out one dot command a cycle while the result queue can take it: latches
// fetch data, shifts, issues fetch addresses, moves the scroll address and picks the pixel.
// ----------------------------------------------------------------------------
module tbfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tbfs_pkg::cfg_t    cfg,
  input  logic              cmd_valid,
  input  tbfs_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output tbfs_pkg::result_t res
);
  import tbfs_pkg::*;

  logic [14:0]  scroll_r, scroll_nxt;
  logic [15:0]  pat_lo_r, pat_lo_nxt;
  logic [15:0]  pat_hi_r, pat_hi_nxt;
  logic [15:0]  att_lo_r, att_lo_nxt;
  logic [15:0]  att_hi_r, att_hi_nxt;
  logic [7:0]   idx_r, idx_nxt;
  logic [1:0]   attr_r, attr_nxt;
  logic [7:0]   low_r, low_nxt;
  logic [7:0]   high_r, high_nxt;
  fetch_kind_t  pend_r, pend_nxt;
  logic         render_on;
  logic [4:0]   row_y;
  logic [3:0]   bit_sel;
  logic [1:0]   pix;
  logic [1:0]   pal;
  result_t      r;

  result_t              oq_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] oq_wr_r;
  logic [OUT_PTR_W-1:0] oq_rd_r;
  logic [OUT_CNT_W-1:0] oq_count_r;
  logic [OUT_CNT_W-1:0] oq_count_nxt;
  logic                 oq_full;
  logic                 pop_ok;

  assign oq_full   = (oq_count_r == OUT_CNT_W'(OUT_DEPTH));
  assign out_empty = (oq_count_r == '0);
  assign pop_ok    = out_pop && !out_empty;
  assign cmd_pop   = cmd_valid && (!oq_full || pop_ok);
  assign res       = oq_r[oq_rd_r];
  assign render_on = cfg.bg_enable || cfg.spr_enable;

  always_comb begin
    scroll_nxt = scroll_r;
    pat_lo_nxt = pat_lo_r;
    pat_hi_nxt = pat_hi_r;
    att_lo_nxt = att_lo_r;
    att_hi_nxt = att_hi_r;
    idx_nxt    = idx_r;
    attr_nxt   = attr_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = KIND_NONE;
    row_y      = '0;
    r          = '0;

    // answer to the previous dot's request
    unique case (pend_r)
      KIND_NAME: idx_nxt = cmd.data;
      KIND_ATTR: attr_nxt = cmd.data[{scroll_r[6], scroll_r[1], 1'b0} +: 2];
      KIND_LOW:  low_nxt = cmd.data;
      KIND_HIGH: high_nxt = cmd.data;
      default:   ;
    endcase

    if (cmd.shift && cfg.bg_enable) begin
      pat_lo_nxt = {pat_lo_nxt[14:0], 1'b0};
      pat_hi_nxt = {pat_hi_nxt[14:0], 1'b0};
      att_lo_nxt = {att_lo_nxt[14:0], 1'b0};
      att_hi_nxt = {att_hi_nxt[14:0], 1'b0};
    end
    if (cmd.load) begin
      pat_lo_nxt[7:0] = low_nxt;
      pat_hi_nxt[7:0] = high_nxt;
      att_lo_nxt[7:0] = {8{attr_nxt[0]}};
      att_hi_nxt[7:0] = {8{attr_nxt[1]}};
    end

    // fetch address from the scroll address as it stood before this dot
    r.fetch_valid = (cmd.fetch != KIND_NONE);
    pend_nxt      = cmd.fetch;
    unique case (cmd.fetch)
      KIND_NAME: r.fetch_address = NAME_BASE | {2'b00, scroll_r[11:0]};
      KIND_ATTR: r.fetch_address = {1'b1, 1'b0, scroll_r[11:10], 4'b1111,
                                    scroll_r[9:7], scroll_r[4:2]};
      KIND_LOW:  r.fetch_address = {1'b0, cfg.pattern_half, idx_nxt, 1'b0,
                                    scroll_r[14:12]};
      KIND_HIGH: r.fetch_address = {1'b0, cfg.pattern_half, idx_nxt, 1'b1,
                                    scroll_r[14:12]};
      default:   r.fetch_address = '0;
    endcase

    if (cmd.bump_x && render_on) begin
      if (scroll_nxt[4:0] == COARSE_MAX) begin
        scroll_nxt = {scroll_nxt[14:11], ~scroll_nxt[10], scroll_nxt[9:5], 5'd0};
      end else begin
        scroll_nxt = scroll_nxt + 15'd1;
      end
    end
    if (cmd.bump_y && render_on) begin
      if (scroll_nxt[14:12] != FINE_Y_MAX) begin
        scroll_nxt[14:12] = scroll_nxt[14:12] + 3'd1;
      end else begin
        scroll_nxt[14:12] = 3'd0;
        row_y = scroll_nxt[9:5];
        if (row_y == COARSE_Y_ROW) begin
          row_y          = 5'd0;
          scroll_nxt[11] = ~scroll_nxt[11];
        end else if (row_y == COARSE_MAX) begin
          row_y = 5'd0;
        end else begin
          row_y = row_y + 5'd1;
        end
        scroll_nxt[9:5] = row_y;
      end
    end
    if (cmd.copy_h && render_on) begin
      scroll_nxt[10]  = cfg.temp_address[10];
      scroll_nxt[4:0] = cfg.temp_address[4:0];
    end
    if (cmd.copy_v && render_on) begin
      scroll_nxt[14:11] = cfg.temp_address[14:11];
      scroll_nxt[9:5]   = cfg.temp_address[9:5];
    end

    // shifter bit 15 - fine x
    bit_sel = {1'b1, ~cfg.fine_x};
    pix     = '0;
    pal     = '0;
    if (cfg.bg_enable) begin
      pix = {pat_hi_nxt[bit_sel], pat_lo_nxt[bit_sel]};
      pal = {att_hi_nxt[bit_sel], att_lo_nxt[bit_sel]};
      if (pix == 2'd0) begin
        pal = 2'd0;
      end
    end
    r.pixel_value         = pix;
    r.palette_select      = pal;
    r.palette_ram_address = PALETTE_BASE | {10'd0, pal, pix};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= '0;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      att_lo_r <= '0;
      att_hi_r <= '0;
      idx_r    <= '0;
      attr_r   <= '0;
      low_r    <= '0;
      high_r   <= '0;
      pend_r   <= KIND_NONE;
    end else if (cmd_pop) begin
      scroll_r <= scroll_nxt;
      pat_lo_r <= pat_lo_nxt;
      pat_hi_r <= pat_hi_nxt;
      att_lo_r <= att_lo_nxt;
      att_hi_r <= att_hi_nxt;
      idx_r    <= idx_nxt;
      attr_r   <= attr_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // result queue
  always_comb begin
    oq_count_nxt = oq_count_r;
    if (cmd_pop && !pop_ok) begin
      oq_count_nxt = oq_count_r + 1'b1;
    end else if (!cmd_pop && pop_ok) begin
      oq_count_nxt = oq_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_count_r <= '0;
    end else begin
      oq_count_r <= oq_count_nxt;
      if (cmd_pop) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (pop_ok) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      oq_r[oq_wr_r] <= r;
    end
  end

endmodule

// File: hw/rtl/tile_background_fetch_scroll.sv
// ----------------------------------------------------------------------------
// tile_background_fetch_scroll
// Background tile fetcher and scroll address logic, one request per dot.
// ----------------------------------------------------------------------------
// Usage:
//   Push one request per dot on in_*: dot, scanline (-1 is pre-render) and
//   the byte answered for the fetch issued on the previous dot. Each request
//   gives exactly one result on out_*: the fetch request for this dot (if
//   any), the background pixel, its palette and its palette RAM address.
//   Both sides are queues: in_full holds off pushes, out_empty low means a
//   result is shown and out_pop takes it.
//   A request passes the command queue, then the result queue, to out_*.
//   Throughput: one request per cycle while out_pop keeps up; the front
//   holds a four-entry command queue and the back a two-entry result queue,
//   so a stalled receiver fills those before in_full rises.
//   Configuration is written through cfg_we / cfg_index / cfg_data and is
//   meant to change only while no request is in flight.
//   Reset (rst_n low, synchronous) clears the registers, the scroll state,
//   the shifters, latches and both queues; no fetch is pending after reset.
// ----------------------------------------------------------------------------
module tile_background_fetch_scroll (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [8:0]                      in_dot,
  input  logic signed [9:0]               in_line,
  input  logic [7:0]                      in_fetch_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_fetch_valid,
  output logic [13:0]                     out_fetch_address,
  output logic [1:0]                      out_palette_select,
  output logic [1:0]                      out_pixel_value,
  output logic [13:0]                     out_palette_ram_address,
  input  logic                            cfg_we,
  input  logic [tbfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tbfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tbfs_pkg::*;

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BG_ENABLE:    cfg_nxt.bg_enable    = cfg_data[0];
        CFG_SPR_ENABLE:   cfg_nxt.spr_enable   = cfg_data[0];
        CFG_PATTERN_HALF: cfg_nxt.pattern_half = cfg_data[0];
        CFG_FINE_X:       cfg_nxt.fine_x       = cfg_data[2:0];
        CFG_TEMP_ADDRESS: cfg_nxt.temp_address = cfg_data[14:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tbfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_dot        (in_dot),
    .in_line       (in_line),
    .in_fetch_data (in_fetch_data),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  tbfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_fetch_valid         = res.fetch_valid;
  assign out_fetch_address       = res.fetch_address;
  assign out_palette_select      = res.palette_select;
  assign out_pixel_value         = res.pixel_value;
  assign out_palette_ram_address = res.palette_ram_address;

endmodule
